>>> hdl/xor_checked_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the XOR-checked frame deframer
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define XCFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
`define XCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define XCFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define XCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/xcfd_pkg.sv
// ----------------------------------------------------------------------------
// XOR-checked frame deframer package
// Types and constants shared by the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TDATA_W = 32;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

    // Register index, taken from paddr bit 2.
    localparam logic REG_HEADER_FIRST  = 1'b0;
    localparam logic REG_HEADER_SECOND = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CSUM = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

>>> hdl/xor_checked_frame_deframer.sv
// ----------------------------------------------------------------------------
// XOR-checked frame deframer
// Hunts for a two-byte header, then a length byte, the payload and an XOR
// checksum, giving out each payload byte and an end marker with a pass flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid/tready           rx_byte
// m_axis    out        tvalid/tready           tdata fields, tuser item_kind
// apb       in         psel/penable/pready     header_first, header_second
//
// One byte is taken per cycle while the input register is free or the output
// can advance; a byte is held in the input register and its result is then
// registered into the output register, together with the frame state update.
// Reset is synchronous, restarts the frame hunt and returns both header
// registers to their reset values.
// A stalled output holds the input register; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_frame_deframer_assert.svh"

module xor_checked_frame_deframer
    import xcfd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] payload_byte, [15:8] byte_index, [23:16] frame_length,
    // [24] checksum_ok, [31:25] zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tuser,   // [0] item_kind
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte,  n_in_byte;
    logic              r_out_valid, n_out_valid;
    logic              r_out_kind,  n_out_kind;
    logic [BYTE_W-1:0] r_out_data,  n_out_data;
    logic [BYTE_W-1:0] r_out_idx,   n_out_idx;
    logic [BYTE_W-1:0] r_out_len,   n_out_len;
    logic              r_out_ok,    n_out_ok;
    t_phase            r_phase,     n_phase;
    logic [BYTE_W-1:0] r_seen,      n_seen;
    logic [BYTE_W-1:0] r_len,       n_len;
    logic [BYTE_W-1:0] r_xor,       n_xor;
    logic [BYTE_W-1:0] r_hdr_first, n_hdr_first;
    logic [BYTE_W-1:0] r_hdr_second, n_hdr_second;

    logic              adv;
    logic              proc;
    logic              cfg_wr;
    logic [BYTE_W-1:0] seen_inc;
    logic [BYTE_W-1:0] data_xor;

    assign adv           = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign seen_inc      = r_seen + 8'd1;
    assign data_xor      = r_xor ^ r_in_byte;

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {7'd0, r_out_ok, r_out_len, r_out_idx, r_out_data};

    always_comb begin
        n_hdr_first  = r_hdr_first;
        n_hdr_second = r_hdr_second;
        if (cfg_wr) begin
            if (paddr[2] == REG_HEADER_FIRST) begin
                n_hdr_first = pwdata[BYTE_W-1:0];
            end else begin
                n_hdr_second = pwdata[BYTE_W-1:0];
            end
        end
        if (paddr[2] == REG_HEADER_SECOND) begin
            prdata = {24'd0, r_hdr_second};
        end else begin
            prdata = {24'd0, r_hdr_first};
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        if (s_axis_tvalid && s_axis_tready) begin
            n_in_valid = 1'b1;
            n_in_byte  = s_axis_tdata;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_idx   = r_out_idx;
        n_out_len   = r_out_len;
        n_out_ok    = r_out_ok;
        n_phase     = r_phase;
        n_seen      = r_seen;
        n_len       = r_len;
        n_xor       = r_xor;

        if (proc) begin
            case (r_phase)
                PH_HDR0: begin
                    if (r_in_byte == r_hdr_first) begin
                        n_phase = PH_HDR1;
                    end
                end
                PH_HDR1: begin
                    n_phase = (r_in_byte == r_hdr_second) ? PH_LEN : PH_HDR0;
                end
                PH_LEN: begin
                    n_len   = r_in_byte;
                    n_xor   = r_in_byte;
                    n_seen  = '0;
                    n_phase = (r_in_byte == '0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA: begin
                    n_xor       = data_xor;
                    n_seen      = seen_inc;
                    if (seen_inc == r_len) begin
                        n_phase = PH_CSUM;
                    end
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_PAYLOAD;
                    n_out_data  = r_in_byte;
                    n_out_idx   = r_seen;
                    n_out_len   = r_len;
                    n_out_ok    = 1'b0;
                end
                PH_CSUM: begin
                    n_phase     = PH_HDR0;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_END;
                    n_out_data  = '0;
                    n_out_idx   = '0;
                    n_out_len   = r_len;
                    n_out_ok    = (r_xor == r_in_byte);
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_HDR0;
            r_seen       <= '0;
            r_len        <= '0;
            r_xor        <= '0;
            r_hdr_first  <= HEADER_FIRST_RST;
            r_hdr_second <= HEADER_SECOND_RST;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_phase      <= n_phase;
            r_seen       <= n_seen;
            r_len        <= n_len;
            r_xor        <= n_xor;
            r_hdr_first  <= n_hdr_first;
            r_hdr_second <= n_hdr_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte  <= n_in_byte;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_idx  <= n_out_idx;
        r_out_len  <= n_out_len;
        r_out_ok   <= n_out_ok;
    end

    `XCFD_ASSERT_IMP(a_end_fields_zero, i_clk, i_rst_n, r_out_valid && (r_out_kind == KIND_END), (r_out_data == '0) && (r_out_idx == '0))
    `XCFD_ASSERT_IMP(a_data_count_below_len, i_clk, i_rst_n, r_phase == PH_DATA, r_seen != r_len)
    `XCFD_ASSERT_IMP(a_no_overwrite_input, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && r_in_valid, adv)
    `XCFD_ASSERT_NEXT(a_last_byte_to_csum, i_clk, i_rst_n, proc && (r_phase == PH_DATA) && (seen_inc == r_len), r_phase == PH_CSUM)

endmodule

`default_nettype wire

>>> verif/tb_xor_checked_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the XOR-checked frame deframer
// Streams a short directed table and then random frames, broken headers and
// line noise through the deframer. A predictor follows the frame hunt and
// computes every payload byte and end marker. Each output request is compared
// field by field with the oldest prediction. Both stream sides idle at random.
// The header bytes are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_deframer;
    import xcfd_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PHASE_ITEMS  = 300;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned NUM_PHASES   = 5;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] length;
        logic              ok;
    } deframed_t;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                typed;
        deframed_t         want;
    } stim_row_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    deframed_t           pending_results[$];
    int unsigned         error_count   = 0;
    int unsigned         cycle_count   = 0;
    int unsigned         frame_items   = 0;
    int unsigned         burst_left    = 0;
    int unsigned         gap_max       = 6;
    bit                  hold_request  = 1'b0;

    // Predictor state and its copy of the header registers.
    logic [BYTE_W-1:0]   sof_first;
    logic [BYTE_W-1:0]   sof_second;
    t_phase              hunt_phase;
    logic [BYTE_W-1:0]   payload_count;
    logic [BYTE_W-1:0]   length_seen;
    logic [BYTE_W-1:0]   xor_acc;

    xor_checked_frame_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output deframed_t res);
        bit has;
        has = 1'b0;
        res = '0;
        case (hunt_phase)
            PH_HDR0: begin
                if (b == sof_first) hunt_phase = PH_HDR1;
            end
            PH_HDR1: begin
                hunt_phase = (b == sof_second) ? PH_LEN : PH_HDR0;
            end
            PH_LEN: begin
                length_seen   = b;
                xor_acc       = b;
                payload_count = '0;
                hunt_phase    = (b == '0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                res = deframed_t'({KIND_PAYLOAD, b, payload_count, length_seen, 1'b0});
                xor_acc       = xor_acc ^ b;
                payload_count = payload_count + 1'b1;
                if (payload_count == length_seen) hunt_phase = PH_CSUM;
                has = 1'b1;
            end
            PH_CSUM: begin
                res = deframed_t'({KIND_END, 8'h00, 8'h00, length_seen, xor_acc == b});
                hunt_phase = PH_HDR0;
                has = 1'b1;
            end
            default: begin
                hunt_phase = PH_HDR0;
            end
        endcase
        return has;
    endfunction

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        deframed_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("item_kind", {7'b0, want.kind}, {7'b0, m_axis_tuser});
                check_field("payload_byte", want.data, m_axis_tdata[7:0]);
                check_field("byte_index", want.index, m_axis_tdata[15:8]);
                check_field("frame_length", want.length, m_axis_tdata[23:16]);
                check_field("checksum_ok", {7'b0, want.ok}, {7'b0, m_axis_tdata[24]});
                check_field("tdata padding", 8'h00, {1'b0, m_axis_tdata[31:25]});
            end
        end
    end

    // The receiver works through stretches of its own stall patterns. On
    // request it holds off for a long stretch so that the deframer fills up.
    initial begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned held;
        forever begin
            mode = $urandom_range(3, 0);
            span = $urandom_range(80, 10);
            for (int c = 0; c < span; c++) begin
                @(posedge i_clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(1, 0) != 0);
                    2: m_axis_tready <= (c % 4 == 3);
                    default: m_axis_tready <= ($urandom_range(7, 0) != 0);
                endcase
            end
            if (hold_request) begin
                hold_request = 1'b0;
                held = 0;
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
                while (held < LONG_HOLD) begin
                    @(posedge i_clk);
                    held++;
                end
            end
        end
    end

    task automatic offer_byte(input logic [BYTE_W-1:0] b, input bit typed, input deframed_t want);
        deframed_t   predicted;
        bit          has;
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        has = deframe_byte(b, predicted);
        if (typed) pending_results.push_back(want);
        else if (has) pending_results.push_back(predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(24, 1);
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(input logic reg_sel, input logic [BYTE_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word      = $urandom;
        word[7:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_sel == REG_HEADER_FIRST) sof_first = value;
        else sof_second = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_frame(input int unsigned len, input bit good_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] flip;
        sum = len[7:0];
        offer_byte(sof_first, 1'b0, '0);
        offer_byte(sof_second, 1'b0, '0);
        offer_byte(len[7:0], 1'b0, '0);
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            offer_byte(b, 1'b0, '0);
        end
        flip = 8'($urandom_range(255, 1));
        offer_byte(good_sum ? sum : sum ^ flip, 1'b0, '0);
        frame_items += len + 4;
    endtask

    task automatic run_random_phase(input int unsigned target);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        int unsigned n;
        logic [BYTE_W-1:0] b;
        start = frame_items;
        while (frame_items - start < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 75) begin
                n = $urandom_range(99, 0);
                if (n < 70) len = $urandom_range(6, 0);
                else if (n < 96) len = $urandom_range(40, 7);
                else len = $urandom_range(255, 128);
                send_frame(len, $urandom_range(3, 0) != 0);
            end else if (pick < 87) begin
                // A first header byte followed by a wrong second one.
                b = 8'($urandom);
                if (b == sof_second) b = ~b;
                offer_byte(sof_first, 1'b0, '0);
                offer_byte(b, 1'b0, '0);
                frame_items += 2;
            end else begin
                n = $urandom_range(6, 1);
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == sof_first && $urandom_range(3, 0) != 0) b = ~b;
                    offer_byte(b, 1'b0, '0);
                end
                frame_items += n;
            end
        end
    endtask

    initial begin : stimulus
        stim_row_t         rows[$];
        logic [BYTE_W-1:0] first_val;
        logic [BYTE_W-1:0] second_val;

        sof_first     = HEADER_FIRST_RST;
        sof_second    = HEADER_SECOND_RST;
        hunt_phase    = PH_HDR0;
        payload_count = '0;
        length_seen   = '0;
        xor_acc       = '0;

        // Zero length frame straight after reset.
        rows.push_back('{8'hAA, 1'b0, '0});
        rows.push_back('{8'h55, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, '0});
        rows.push_back('{8'h00, 1'b1, deframed_t'({KIND_END, 8'h00, 8'h00, 8'h00, 1'b1})});
        // One byte of all ones with a good checksum.
        rows.push_back('{8'hAA, 1'b0, '0});
        rows.push_back('{8'h55, 1'b0, '0});
        rows.push_back('{8'h01, 1'b0, '0});
        rows.push_back('{8'hFF, 1'b1, deframed_t'({KIND_PAYLOAD, 8'hFF, 8'h00, 8'h01, 1'b0})});
        rows.push_back('{8'hFE, 1'b1, deframed_t'({KIND_END, 8'h00, 8'h00, 8'h01, 1'b1})});
        // One zero byte with a bad checksum.
        rows.push_back('{8'hAA, 1'b0, '0});
        rows.push_back('{8'h55, 1'b0, '0});
        rows.push_back('{8'h01, 1'b0, '0});
        rows.push_back('{8'h00, 1'b1, deframed_t'({KIND_PAYLOAD, 8'h00, 8'h00, 8'h01, 1'b0})});
        rows.push_back('{8'h00, 1'b1, deframed_t'({KIND_END, 8'h00, 8'h00, 8'h01, 1'b0})});
        // Second header mismatch: the mismatching byte does not restart the hunt.
        rows.push_back('{8'hAA, 1'b0, '0});
        rows.push_back('{8'hAA, 1'b0, '0});
        rows.push_back('{8'h55, 1'b0, '0});
        rows.push_back('{8'hAA, 1'b0, '0});
        rows.push_back('{8'h55, 1'b0, '0});
        rows.push_back('{8'h02, 1'b0, '0});
        rows.push_back('{8'h12, 1'b0, '0});
        rows.push_back('{8'h34, 1'b0, '0});
        rows.push_back('{8'h24, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) offer_byte(rows[i].rx, rows[i].typed, rows[i].want);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    first_val  = HEADER_FIRST_RST;
                    second_val = HEADER_SECOND_RST;
                end
                1: begin
                    first_val  = 8'h00;
                    second_val = 8'hFF;
                end
                2: begin
                    first_val  = 8'hFF;
                    second_val = 8'h00;
                end
                3: begin
                    first_val  = 8'($urandom);
                    second_val = 8'($urandom);
                end
                default: begin
                    first_val  = 8'($urandom);
                    second_val = first_val;
                end
            endcase
            write_header(REG_HEADER_FIRST, first_val);
            write_header(REG_HEADER_SECOND, second_val);
            gap_max = (p == 1) ? 0 : ((p == 3) ? 12 : 5);
            if (p == 1) hold_request = 1'b1;
            if (p == 0) send_frame(255, 1'b1);
            if (p == 2) send_frame(255, 1'b0);
            run_random_phase(PHASE_ITEMS);
            settle();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
